[hdl/brp_pkg.sv]
// Shared types and codes of the route planner.
package brp_pkg;

   localparam int STOP_W = 6;
   localparam int LINE_W = 8;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
   localparam logic [OP_W-1:0] OP_CONNECT  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNKNOWN     = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNREACHABLE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL        = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [STOP_W-1:0] stop_a;
      logic [STOP_W-1:0] stop_b;
      logic [LINE_W-1:0] line_id;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [STOP_W-1:0] route_stop;
      logic [LINE_W-1:0] onward_line;
      logic              has_onward;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]   kind;
      logic              range_err;
      logic [STOP_W-1:0] stop_a;
      logic [STOP_W-1:0] stop_b;
      logic [LINE_W-1:0] line_id;
   } cmd_type;

endpackage

[hdl/brp_ram.sv]
// Generic single write port RAM with registered read.
module brp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[hdl/brp_queue.sv]
// Small register FIFO.
module brp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == NW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         cnt_in = NW'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = NW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule

[hdl/brp_front.sv]
// Request intake: range classification and command queue.
module brp_front #(
   parameter int MAX_STOPS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  brp_pkg::req_type req_data,
   output logic             req_full,
   input  logic             cmd_pop,
   output brp_pkg::cmd_type cmd,
   output logic             cmd_valid
);
   brp_pkg::cmd_type cls;
   logic             enq, cmd_empty;

   always_comb begin
      cls.kind      = req_data.operation;
      cls.stop_a    = req_data.stop_a;
      cls.stop_b    = req_data.stop_b;
      cls.line_id   = req_data.line_id;
      cls.range_err = (32'(req_data.stop_a) >= MAX_STOPS) ||
                      ((req_data.operation != brp_pkg::OP_REGISTER) &&
                       (32'(req_data.stop_b) >= MAX_STOPS));
   end

   // operation three is taken and dropped
   assign enq = req_push && (req_data.operation != brp_pkg::OP_NONE);

   brp_queue #(.WIDTH($bits(brp_pkg::cmd_type)), .DEPTH(2)) u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (enq),
      .wdata (cls),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd),
      .empty (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
endmodule

[hdl/brp_engine.sv]
// Command execution: graph store, breadth-first search and route output.
module brp_engine #(
   parameter int MAX_STOPS  = 64,
   parameter int MAX_DEGREE = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  brp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             out_full,
   output logic             out_push,
   output brp_pkg::rsp_type out_data
);
   localparam int SW     = $clog2(MAX_STOPS);
   localparam int CW     = $clog2(MAX_STOPS + 1);
   localparam int DW     = $clog2(MAX_DEGREE + 1);
   localparam int EDEPTH = MAX_STOPS * MAX_DEGREE;
   localparam int EW     = $clog2(EDEPTH);
   localparam int PW     = SW + brp_pkg::LINE_W;
   localparam int KW     = PW + 1;
   localparam int LW     = brp_pkg::LINE_W;

   typedef enum logic [3:0] {
      S_IDLE, S_CONN, S_RESP, S_DEQ, S_DEQ_WAIT, S_CNT_WAIT, S_EDGE,
      S_WALK_RD, S_POP, S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   brp_pkg::cmd_type          cmd_ff, cmd_in;
   logic [SW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             head_ff, head_in, tail_ff, tail_in, depth_ff, depth_in;
   logic [DW-1:0]             idx_ff, idx_in, ncnt_ff, ncnt_in;
   logic [brp_pkg::STAT_W-1:0] status_ff, status_in;
   logic [MAX_STOPS-1:0]      known_ff, known_in, seen_ff, seen_in, cval_ff, cval_in;

   logic          cnt_we, cnt_re;
   logic [SW-1:0] cnt_waddr, cnt_raddr;
   logic [DW-1:0] cnt_wdata, cnt_rdata, cnt_now;
   logic          edge_we, edge_re;
   logic [EW-1:0] edge_waddr, edge_raddr;
   logic [PW-1:0] edge_wdata, edge_rdata;
   logic          q_we, q_re;
   logic [SW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
   logic          par_we, par_re;
   logic [SW-1:0] par_waddr, par_raddr;
   logic [PW-1:0] par_wdata, par_rdata;
   logic          stk_we, stk_re;
   logic [SW-1:0] stk_waddr, stk_raddr;
   logic [KW-1:0] stk_wdata, stk_rdata;

   logic [SW-1:0] sa, sb, nx, pst;
   logic [DW-1:0] idx_nx;

   function automatic logic [EW-1:0] eaddr(input logic [SW-1:0] s, input logic [DW-1:0] i);
      eaddr = EW'(32'(s) * MAX_DEGREE + 32'(i));
   endfunction

   assign sa     = cmd_ff.stop_a[SW-1:0];
   assign sb     = cmd_ff.stop_b[SW-1:0];
   assign nx     = edge_rdata[PW-1:LW];
   assign pst    = par_rdata[PW-1:LW];
   assign idx_nx = DW'(idx_ff + 1'b1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      depth_in  = depth_ff;
      idx_in    = idx_ff;
      ncnt_in   = ncnt_ff;
      status_in = status_ff;
      known_in  = known_ff;
      seen_in   = seen_ff;
      cval_in   = cval_ff;
      cmd_pop   = 1'b0;
      cnt_we    = 1'b0;
      cnt_re    = 1'b0;
      cnt_waddr = sa;
      cnt_raddr = cmd.stop_a[SW-1:0];
      cnt_now   = cval_ff[sa] ? cnt_rdata : '0;
      cnt_wdata = DW'(cnt_now + 1'b1);
      edge_we    = 1'b0;
      edge_re    = 1'b0;
      edge_waddr = eaddr(sa, cnt_now);
      edge_raddr = eaddr(cur_ff, '0);
      edge_wdata = {sb, cmd_ff.line_id};
      q_we      = 1'b0;
      q_re      = 1'b0;
      q_waddr   = tail_ff[SW-1:0];
      q_raddr   = head_ff[SW-1:0];
      q_wdata   = nx;
      par_we    = 1'b0;
      par_re    = 1'b0;
      par_waddr = nx;
      par_raddr = sb;
      par_wdata = {cur_ff, edge_rdata[LW-1:0]};
      stk_we    = 1'b0;
      stk_re    = 1'b0;
      stk_waddr = depth_ff[SW-1:0];
      stk_raddr = SW'(depth_ff - 1'b1);
      stk_wdata = {pst, par_rdata[LW-1:0], 1'b1};
      out_push  = 1'b0;
      out_data  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               cnt_re  = 1'b1;
               unique case (cmd.kind)
                  brp_pkg::OP_REGISTER: begin
                     state_in = S_RESP;
                     if (cmd.range_err) begin
                        status_in = brp_pkg::ST_UNKNOWN;
                     end else begin
                        status_in = brp_pkg::ST_OK;
                        known_in[cmd.stop_a[SW-1:0]] = 1'b1;
                     end
                  end
                  brp_pkg::OP_CONNECT: begin
                     if (cmd.range_err) begin
                        status_in = brp_pkg::ST_UNKNOWN;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_CONN;
                     end
                  end
                  brp_pkg::OP_QUERY: begin
                     if (cmd.range_err || !known_ff[cmd.stop_a[SW-1:0]] ||
                         !known_ff[cmd.stop_b[SW-1:0]]) begin
                        status_in = brp_pkg::ST_UNKNOWN;
                        state_in  = S_RESP;
                     end else begin
                        seen_in = '0;
                        seen_in[cmd.stop_a[SW-1:0]] = 1'b1;
                        q_we     = 1'b1;
                        q_waddr  = '0;
                        q_wdata  = cmd.stop_a[SW-1:0];
                        head_in  = '0;
                        tail_in  = CW'(1);
                        state_in = S_DEQ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CONN: begin
            if (32'(cnt_now) >= MAX_DEGREE) begin
               status_in = brp_pkg::ST_FULL;
            end else begin
               status_in   = brp_pkg::ST_OK;
               edge_we     = 1'b1;
               cnt_we      = 1'b1;
               cval_in[sa] = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!out_full) begin
               out_push        = 1'b1;
               out_data.status = status_ff;
               out_data.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DEQ: begin
            if (head_ff == tail_ff) begin
               status_in = brp_pkg::ST_UNREACHABLE;
               state_in  = S_RESP;
            end else begin
               q_re     = 1'b1;
               head_in  = CW'(head_ff + 1'b1);
               state_in = S_DEQ_WAIT;
            end
         end
         S_DEQ_WAIT: begin
            cur_in = q_rdata;
            if (q_rdata == sb) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = {sb, {LW{1'b0}}, 1'b0};
               depth_in  = CW'(1);
               if (sb == sa) begin
                  state_in = S_POP;
               end else begin
                  par_re   = 1'b1;
                  state_in = S_WALK_RD;
               end
            end else begin
               cnt_re    = 1'b1;
               cnt_raddr = q_rdata;
               state_in  = S_CNT_WAIT;
            end
         end
         S_CNT_WAIT: begin
            ncnt_in = cval_ff[cur_ff] ? cnt_rdata : '0;
            idx_in  = '0;
            if (ncnt_in == '0) begin
               state_in = S_DEQ;
            end else begin
               edge_re  = 1'b1;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (!seen_ff[nx]) begin
               seen_in[nx] = 1'b1;
               par_we      = 1'b1;
               q_we        = 1'b1;
               tail_in     = CW'(tail_ff + 1'b1);
            end
            idx_in = idx_nx;
            if (idx_nx == ncnt_ff) begin
               state_in = S_DEQ;
            end else begin
               edge_re    = 1'b1;
               edge_raddr = eaddr(cur_ff, idx_nx);
            end
         end
         S_WALK_RD: begin
            stk_we   = 1'b1;
            depth_in = CW'(depth_ff + 1'b1);
            if (pst == sa) begin
               state_in = S_POP;
            end else begin
               par_re    = 1'b1;
               par_raddr = pst;
            end
         end
         S_POP: begin
            stk_re   = 1'b1;
            depth_in = CW'(depth_ff - 1'b1);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_full) begin
               out_push             = 1'b1;
               out_data.status      = brp_pkg::ST_OK;
               out_data.route_stop  = brp_pkg::STOP_W'(stk_rdata[KW-1:LW+1]);
               out_data.onward_line = stk_rdata[LW:1];
               out_data.has_onward  = stk_rdata[0];
               out_data.last        = (depth_ff == '0);
               if (depth_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  stk_re   = 1'b1;
                  depth_in = CW'(depth_ff - 1'b1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         known_ff <= '0;
         cval_ff  <= '0;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         known_ff <= known_in;
         cval_ff  <= cval_in;
         seen_ff  <= seen_in;
      end
      cmd_ff    <= cmd_in;
      cur_ff    <= cur_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
      depth_ff  <= depth_in;
      idx_ff    <= idx_in;
      ncnt_ff   <= ncnt_in;
      status_ff <= status_in;
   end

   brp_ram #(.WIDTH(DW), .DEPTH(MAX_STOPS)) u_count (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
   );

   brp_ram #(.WIDTH(PW), .DEPTH(EDEPTH)) u_edges (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
   );

   brp_ram #(.WIDTH(SW), .DEPTH(MAX_STOPS)) u_search_q (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
   );

   brp_ram #(.WIDTH(PW), .DEPTH(MAX_STOPS)) u_parent (
      .clock(clock), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
      .re(par_re), .raddr(par_raddr), .rdata(par_rdata)
   );

   brp_ram #(.WIDTH(KW), .DEPTH(MAX_STOPS)) u_route (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
   );
endmodule

[hdl/bfs_route_planner.sv]
// Top level of the breadth-first route planner.
// Requests enter through a queue port: an item transfers when req_push is high and
// req_full is low. Operations: register a stop, add a directed connection with a
// line label, or ask for a route between two registered stops.
// Results leave through a queue port: the oldest result shows while rsp_empty is
// low and transfers when rsp_pop is high. Register and connect give one result;
// a query gives one result per route stop from start to target, the final one
// flagged with last, or a single error result.
// A query dequeues stops from the search queue and scans each one's connections,
// then unwinds parent links onto a route stack and emits the route stops from it.
// A two-entry command queue lets requests arrive while a query runs; a two-entry
// result queue lets the engine run ahead of a stalled receiver, beyond which the
// engine waits. Reset clears the stop registry and all connection lists at once.
module bfs_route_planner #(
   parameter int MAX_STOPS  = 64,
   parameter int MAX_DEGREE = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  brp_pkg::req_type req_data,
   output logic             req_full,
   input  logic             rsp_pop,
   output brp_pkg::rsp_type rsp_data,
   output logic             rsp_empty
);
   brp_pkg::cmd_type cmd;
   brp_pkg::rsp_type out_data;
   logic             cmd_valid, cmd_pop, out_push, out_full;

   brp_front #(.MAX_STOPS(MAX_STOPS)) u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_data(req_data),
      .req_full(req_full), .cmd_pop(cmd_pop), .cmd(cmd), .cmd_valid(cmd_valid)
   );

   brp_engine #(.MAX_STOPS(MAX_STOPS), .MAX_DEGREE(MAX_DEGREE)) u_engine (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_pop(cmd_pop), .out_full(out_full), .out_push(out_push),
      .out_data(out_data)
   );

   brp_queue #(.WIDTH($bits(brp_pkg::rsp_type)), .DEPTH(2)) u_rspq (
      .clock(clock), .reset(reset), .push(out_push), .wdata(out_data),
      .full(out_full), .pop(rsp_pop), .rdata(rsp_data), .empty(rsp_empty)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("result pushed into full queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("command taken from empty queue");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty) else $error("result present after reset");
endmodule

[bench/bfs_route_planner_check.sv]
// Checker for the route planner: watches both channels, predicts routes and compares.
`timescale 1ns / 100ps
module bfs_route_planner_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  brp_pkg::req_type req_data,
   input  logic             req_full,
   input  logic             rsp_pop,
   input  brp_pkg::rsp_type rsp_data,
   input  logic             rsp_empty,
   output int               fail_count,
   output int               pending
);
   localparam int NSTOP = 64;
   localparam int NDEG  = 8;

   logic                       known [NSTOP];
   int                         degree [NSTOP];
   logic [brp_pkg::STOP_W-1:0] hop_to [NSTOP*NDEG];
   logic [brp_pkg::LINE_W-1:0] hop_line [NSTOP*NDEG];
   brp_pkg::rsp_type           route_q [$];

   function automatic brp_pkg::rsp_type mk(logic [brp_pkg::STAT_W-1:0] st,
                                           logic [brp_pkg::STOP_W-1:0] s,
                                           logic [brp_pkg::LINE_W-1:0] l,
                                           logic h, logic lst);
      brp_pkg::rsp_type r;
      r.status = st; r.route_stop = s; r.onward_line = l; r.has_onward = h; r.last = lst;
      return r;
   endfunction

   task automatic expect_rsp(brp_pkg::rsp_type r);
      route_q.insert(route_q.size(), r);
   endtask

   task automatic plan(brp_pkg::req_type q);
      logic                       visited [NSTOP];
      logic [brp_pkg::STOP_W-1:0] from_stop [NSTOP];
      logic [brp_pkg::LINE_W-1:0] from_line [NSTOP];
      int                         fifo [$];
      int                         path [$];
      int                         cur, nx, at, a, b;
      a = q.stop_a; b = q.stop_b;
      case (q.operation)
         brp_pkg::OP_REGISTER: begin
            known[a] = 1'b1;
            expect_rsp(mk(brp_pkg::ST_OK, '0, '0, 1'b0, 1'b1));
         end
         brp_pkg::OP_CONNECT: begin
            if (degree[a] >= NDEG) expect_rsp(mk(brp_pkg::ST_FULL, '0, '0, 1'b0, 1'b1));
            else begin
               hop_to[a*NDEG+degree[a]] = q.stop_b;
               hop_line[a*NDEG+degree[a]] = q.line_id;
               degree[a]++;
               expect_rsp(mk(brp_pkg::ST_OK, '0, '0, 1'b0, 1'b1));
            end
         end
         brp_pkg::OP_QUERY: begin
            if (!known[a] || !known[b]) begin
               expect_rsp(mk(brp_pkg::ST_UNKNOWN, '0, '0, 1'b0, 1'b1));
               return;
            end
            foreach (visited[i]) visited[i] = 1'b0;
            visited[a] = 1'b1;
            fifo.insert(fifo.size(), a);
            while (fifo.size() > 0) begin
               cur = fifo.pop_front();
               for (int i = 0; i < degree[cur]; i++) begin
                  nx = hop_to[cur*NDEG+i];
                  if (!visited[nx]) begin
                     visited[nx] = 1'b1;
                     from_stop[nx] = brp_pkg::STOP_W'(cur);
                     from_line[nx] = hop_line[cur*NDEG+i];
                     fifo.insert(fifo.size(), nx);
                  end
               end
               if (cur == b) break;
            end
            if (!visited[b]) begin
               expect_rsp(mk(brp_pkg::ST_UNREACHABLE, '0, '0, 1'b0, 1'b1));
               return;
            end
            at = b;
            while (at != a) begin
               path.push_front(at);
               at = from_stop[at];
            end
            path.push_front(a);
            for (int i = 0; i < path.size(); i++)
               if (i + 1 < path.size())
                  expect_rsp(mk(brp_pkg::ST_OK, brp_pkg::STOP_W'(path[i]),
                                from_line[path[i+1]], 1'b1, 1'b0));
               else
                  expect_rsp(mk(brp_pkg::ST_OK, brp_pkg::STOP_W'(path[i]), '0, 1'b0, 1'b1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      brp_pkg::rsp_type e;
      if (reset) begin
         foreach (known[i]) begin
            known[i] = 1'b0;
            degree[i] = 0;
         end
         route_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (route_q.size() == 0) begin
               $error("unexpected transfer on result channel: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = route_q.pop_front();
               if (rsp_data !== e) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.status !== e.status)
                     $error("status exp %0d got %0d", e.status, rsp_data.status);
                  if (rsp_data.route_stop !== e.route_stop)
                     $error("route_stop exp %0d got %0d", e.route_stop, rsp_data.route_stop);
                  if (rsp_data.onward_line !== e.onward_line)
                     $error("onward_line exp %0d got %0d", e.onward_line,
                            rsp_data.onward_line);
                  if (rsp_data.has_onward !== e.has_onward)
                     $error("has_onward exp %0d got %0d", e.has_onward, rsp_data.has_onward);
                  if (rsp_data.last !== e.last)
                     $error("last exp %0d got %0d", e.last, rsp_data.last);
               end
            end
         end
         if (req_push && !req_full) plan(req_data);
      end
      pending <= route_q.size();
   end
endmodule

[bench/bfs_route_planner_test.sv]
// Testbench top for the route planner: stimulus, reset, timeout and verdict.
`timescale 1ns / 100ps
module bfs_route_planner_test;
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   brp_pkg::req_type req_data = '0;
   logic             req_full;
   logic             rsp_pop = 1'b0;
   brp_pkg::rsp_type rsp_data;
   logic             rsp_empty;
   int               fail_count;
   int               pending;
   int               cycles = 0;
   int               hub [$];

   bfs_route_planner dut (.*);

   bfs_route_planner_check checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stall before each transfer, sometimes none at all
   initial begin
      int gap;
      repeat (9) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   task automatic send(logic [brp_pkg::OP_W-1:0] op, int a, int b, int ln, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{operation: op, stop_a: brp_pkg::STOP_W'(a), stop_b: brp_pkg::STOP_W'(b),
                    line_id: brp_pkg::LINE_W'(ln)};
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   initial begin
      int a, b, r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corner cases
      send(brp_pkg::OP_QUERY, 0, 63, 0);
      send(brp_pkg::OP_REGISTER, 0, 0, 0);
      send(brp_pkg::OP_REGISTER, 63, 63, 255);
      send(brp_pkg::OP_REGISTER, 63, 0, 0);
      send(brp_pkg::OP_QUERY, 0, 0, 0);
      send(brp_pkg::OP_QUERY, 0, 63, 0);
      send(brp_pkg::OP_QUERY, 0, 5, 0);
      send(brp_pkg::OP_CONNECT, 0, 5, 8'h55);
      send(brp_pkg::OP_CONNECT, 5, 63, 8'hAA);
      send(brp_pkg::OP_CONNECT, 0, 63, 8'hFF);
      send(brp_pkg::OP_QUERY, 0, 63, 0);
      send(brp_pkg::OP_NONE, 63, 63, 255);
      for (int i = 0; i < 8; i++) send(brp_pkg::OP_CONNECT, 63, i * 9, i * 32 + 1, i[0]);
      send(brp_pkg::OP_QUERY, 63, 0, 0);
      send(brp_pkg::OP_QUERY, 63, 63, 0);
      // random: register hubs, build a graph, query often
      for (int i = 0; i < 12; i++) begin
         a = $urandom_range(0, 63);
         hub.insert(hub.size(), a);
         send(brp_pkg::OP_REGISTER, a, $urandom_range(0, 63), $urandom_range(0, 255));
      end
      for (int i = 0; i < 86; i++) begin
         r = $urandom_range(0, 9);
         a = (r < 7) ? hub[$urandom_range(0, hub.size() - 1)] : $urandom_range(0, 63);
         b = ($urandom_range(0, 3) != 0) ? hub[$urandom_range(0, hub.size() - 1)]
                                         : $urandom_range(0, 63);
         if (r < 4) send(brp_pkg::OP_CONNECT, a, b, $urandom_range(0, 255),
                         $urandom_range(0, 2) == 0);
         else if (r < 8) send(brp_pkg::OP_QUERY, a, b, $urandom_range(0, 255));
         else if (r < 9) send(brp_pkg::OP_REGISTER, a, b, $urandom_range(0, 255));
         else send(brp_pkg::OP_NONE, a, b, $urandom_range(0, 255));
      end
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
